>>> sv/fbcb_pkg.sv
// Shared types and constants for the page framebuffer column blit unit.
// Used by fbcb_seq and page_framebuffer_column_blit_unit; depends on nothing.
package fbcb_pkg;

    localparam int DEF_COLUMNS = 128;
    localparam int DEF_PAGES   = 4;

    localparam logic [7:0] FILL_ONES  = 8'hFF;
    localparam logic [7:0] FILL_ZEROS = 8'h00;

    typedef enum logic [1:0] {
        CMD_DRAW      = 2'd0,
        CMD_FILL_ALL  = 2'd1,
        CMD_FILL_PAGE = 2'd2,
        CMD_READ      = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL,
        ST_DRAW,
        ST_READ_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       applied;
    } res_t;

endpackage

>>> sv/fbcb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fbcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/fbcb_seq.sv
// Command sequencer and frame store: clear sweep, fills, column read-modify-write, byte read.
// Depends on fbcb_pkg and fbcb_ram.
module fbcb_seq
    import fbcb_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int PAGES   = DEF_PAGES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [6:0]  column_x,
    input  logic [5:0]  row_y,
    input  logic [23:0] column_bits,
    input  logic        tall,
    input  logic        color,
    input  logic [1:0]  page,
    input  logic [8:0]  read_addr,
    output logic        res_valid,
    input  logic        res_ready,
    output res_t        res
);

    localparam int STORE_BYTES = PAGES * COLUMNS;
    localparam int AW          = $clog2(STORE_BYTES);
    localparam int ROWS        = PAGES * 8;

    state_t          state_reg, state_next;
    logic [AW-1:0]   addr_reg, addr_next;
    logic [AW-1:0]   last_reg, last_next;
    logic [AW-1:0]   wr_addr_reg, wr_addr_next;
    logic [7:0]      fill_reg, fill_next;
    logic            color_reg, color_next;
    logic [31:0]     bytes_reg, bytes_next;
    logic [2:0]      step_reg, step_next;
    logic [2:0]      npages_reg, npages_next;
    res_t            res_reg, res_next;

    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [7:0]      ram_wdata, ram_rdata;

    logic            accept;
    logic            draw_ok;
    logic [31:0]     shifted;
    logic [3:0]      pages_left;
    logic [2:0]      pages_want;
    logic [AW-1:0]   draw_base;
    logic [AW-1:0]   page_base;
    logic [7:0]      merged;

    fbcb_ram #(
        .WIDTH(8),
        .DEPTH(STORE_BYTES)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    assign draw_ok = ({1'b0, row_y} < 7'(ROWS))
                  && ({2'b00, column_x} < 9'(COLUMNS))
                  && (!tall || ({1'b0, row_y} + 7'd24 <= 7'(ROWS)));
    assign shifted    = (tall ? {8'h00, column_bits} : {24'h000000, column_bits[7:0]})
                        << row_y[2:0];
    assign pages_left = 4'(PAGES) - {1'b0, row_y[5:3]};
    assign pages_want = tall ? 3'd4 : 3'd2;
    assign draw_base  = AW'(int'(row_y[5:3]) * COLUMNS + int'(column_x));
    assign page_base  = AW'(int'(page) * COLUMNS);
    assign merged     = color_reg ? (ram_rdata | bytes_reg[7:0])
                                  : (ram_rdata & ~bytes_reg[7:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            addr_reg  <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg    <= last_next;
        wr_addr_reg <= wr_addr_next;
        fill_reg    <= fill_next;
        color_reg   <= color_next;
        bytes_reg   <= bytes_next;
        npages_reg  <= npages_next;
        res_reg     <= res_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        addr_next    = addr_reg;
        last_next    = last_reg;
        wr_addr_next = wr_addr_reg;
        fill_next    = fill_reg;
        color_next   = color_reg;
        bytes_next   = bytes_reg;
        step_next    = step_reg;
        npages_next  = npages_reg;
        res_next     = res_reg;
        ram_we       = 1'b0;
        ram_waddr    = addr_reg;
        ram_wdata    = fill_reg;
        ram_re       = 1'b0;
        ram_raddr    = addr_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = FILL_ZEROS;
                if (addr_reg == AW'(STORE_BYTES - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    res_next.read_data = 8'h00;
                    res_next.applied   = 1'b0;
                    fill_next          = color ? FILL_ONES : FILL_ZEROS;
                    state_next         = ST_DONE;
                    case (cmd_t'(cmd))
                        CMD_DRAW:
                        begin
                            if (draw_ok)
                            begin
                                res_next.applied = 1'b1;
                                addr_next        = draw_base;
                                bytes_next       = shifted;
                                color_next       = color;
                                step_next        = '0;
                                npages_next      = (pages_left < {1'b0, pages_want})
                                                   ? pages_left[2:0] : pages_want;
                                state_next       = ST_DRAW;
                            end
                        end
                        CMD_FILL_ALL:
                        begin
                            res_next.applied = 1'b1;
                            addr_next        = '0;
                            last_next        = AW'(STORE_BYTES - 1);
                            state_next       = ST_FILL;
                        end
                        CMD_FILL_PAGE:
                        begin
                            if (int'(page) < PAGES)
                            begin
                                res_next.applied = 1'b1;
                                addr_next        = page_base;
                                last_next        = page_base + AW'(COLUMNS - 1);
                                state_next       = ST_FILL;
                            end
                        end
                        CMD_READ:
                        begin
                            if (int'(read_addr) < STORE_BYTES)
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = AW'(read_addr);
                                state_next = ST_READ_WAIT;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_FILL:
            begin
                ram_we = 1'b1;
                if (addr_reg == last_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end

            ST_DRAW:
            begin
                // Read of one page overlaps the write-back of the page above it.
                if (step_reg < npages_reg)
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = addr_reg;
                    addr_next    = addr_reg + AW'(COLUMNS);
                    wr_addr_next = addr_reg;
                end
                if (step_reg != 3'd0)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = wr_addr_reg;
                    ram_wdata  = merged;
                    bytes_next = bytes_reg >> 8;
                end
                if (step_reg == npages_reg)
                begin
                    state_next = ST_DONE;
                end
                step_next = step_reg + 1'b1;
            end

            ST_READ_WAIT:
            begin
                res_next.read_data = ram_rdata;
                res_next.applied   = 1'b1;
                state_next         = ST_DONE;
            end

            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_no_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !ram_we)
        else $error("Frame store written while waiting for a command.");

    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("Read and write hit the same frame byte in one cycle.");

    a_draw_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAW) |-> (step_reg <= npages_reg && npages_reg != 3'd0
                                    && npages_reg <= 3'd4))
        else $error("Column draw stepped past its last page.");

    a_read_then_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ_WAIT) |=> (state_reg == ST_DONE && res_reg.applied))
        else $error("Byte read did not produce an applied result.");

endmodule

>>> sv/page_framebuffer_column_blit_unit.sv
// Top level of the page framebuffer column blit unit: sequencer plus output word register.
// Depends on fbcb_pkg and fbcb_seq.
//
//   Channel  Handshake              Payload
//   input    in_valid / in_ready    cmd, column_x, row_y, column_bits, tall, color, page, read_addr
//   output   out_valid / out_ready  read_data, applied
//
// In a column draw the page loop shares the single frame store port pair, reading one
// page while writing back the previous.
// A byte read waits in ST_READ_WAIT for the store data; a rejected word goes straight to
// ST_DONE. A page fill or a full fill writes one store byte per cycle.
// After reset the store is cleared to zero before the first word is taken.
// A result waits in the output register; the next word is taken while it waits.
module page_framebuffer_column_blit_unit
    import fbcb_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int PAGES   = DEF_PAGES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [6:0]  column_x,
    input  logic [5:0]  row_y,
    input  logic [23:0] column_bits,
    input  logic        tall,
    input  logic        color,
    input  logic [1:0]  page,
    input  logic [8:0]  read_addr,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_data,
    output logic        applied
);

    logic  res_valid;
    logic  res_ready;
    res_t  res;
    logic  out_valid_reg, out_valid_next;
    res_t  out_reg, out_next;

    fbcb_seq #(
        .COLUMNS(COLUMNS),
        .PAGES  (PAGES)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .column_x   (column_x),
        .row_y      (row_y),
        .column_bits(column_bits),
        .tall       (tall),
        .color      (color),
        .page       (page),
        .read_addr  (read_addr),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign read_data = out_reg.read_data;
    assign applied   = out_reg.applied;

    a_handoff_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready) |=> out_valid)
        else $error("Finished result was not captured in the output register.");

    a_rejected_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !applied) |-> (read_data == 8'h00))
        else $error("Rejected word carries nonzero read data.");

endmodule

>>> tb/sv/page_framebuffer_column_blit_unit_tb.sv
// Self-checking testbench for page_framebuffer_column_blit_unit: column draws, fills and
// byte reads checked word by word against a shadow copy of the frame store.
// Depends on fbcb_pkg and the page_framebuffer_column_blit_unit RTL.
module page_framebuffer_column_blit_unit_tb
    import fbcb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLUMNS     = DEF_COLUMNS;
    localparam int PAGES       = DEF_PAGES;
    localparam int ROWS        = PAGES * 8;
    localparam int STORE_BYTES = PAGES * COLUMNS;
    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 40;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  cmd = CMD_READ;
    logic [6:0]  column_x = '0;
    logic [5:0]  row_y = '0;
    logic [23:0] column_bits = '0;
    logic        tall = 1'b0;
    logic        color = 1'b0;
    logic [1:0]  page = '0;
    logic [8:0]  read_addr = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  read_data;
    logic        applied;

    logic [7:0] frame_shadow [STORE_BYTES];
    res_t       pending_replies [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches = 0;
    int replies_checked = 0;
    int stall_cycles = 0;
    int draws_sent = 0;
    int draws_rejected = 0;
    int fills_sent = 0;
    int reads_sent = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    page_framebuffer_column_blit_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .column_x    (column_x),
        .row_y       (row_y),
        .column_bits (column_bits),
        .tall        (tall),
        .color       (color),
        .page        (page),
        .read_addr   (read_addr),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_data   (read_data),
        .applied     (applied)
    );

    function automatic res_t blit_predict(cmd_t c, logic [6:0] x, logic [5:0] y,
                                          logic [23:0] bits, logic t, logic col,
                                          logic [1:0] pg, logic [8:0] addr);
        res_t       r;
        logic [7:0] fill;
        logic [31:0] spread;
        logic [7:0] lane;
        int         target;
        int         idx;
        r = '0;
        fill = col ? FILL_ONES : FILL_ZEROS;
        case (c)
            CMD_DRAW:
            begin
                if (y < ROWS && x < COLUMNS && !(t && (int'(y) + 24 > ROWS)))
                begin
                    spread = {8'h00, (t ? bits : {16'h0000, bits[7:0]})} << y[2:0];
                    for (int p = 0; p < 4; p++)
                    begin
                        target = int'(y[5:3]) + p;
                        if (target < PAGES)
                        begin
                            idx = target * COLUMNS + int'(x);
                            lane = spread[p*8 +: 8];
                            frame_shadow[idx] = col ? (frame_shadow[idx] | lane)
                                                    : (frame_shadow[idx] & ~lane);
                        end
                    end
                    r.applied = 1'b1;
                end
            end
            CMD_FILL_ALL:
            begin
                foreach (frame_shadow[i])
                    frame_shadow[i] = fill;
                r.applied = 1'b1;
            end
            CMD_FILL_PAGE:
            begin
                if (pg < PAGES)
                begin
                    for (int i = 0; i < COLUMNS; i++)
                        frame_shadow[int'(pg) * COLUMNS + i] = fill;
                    r.applied = 1'b1;
                end
            end
            default:
            begin
                if (addr < STORE_BYTES)
                begin
                    r.read_data = frame_shadow[addr];
                    r.applied = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    task automatic send_word(cmd_t c, logic [6:0] x, logic [5:0] y, logic [23:0] bits,
                             logic t, logic col, logic [1:0] pg, logic [8:0] addr);
        res_t r;
        in_valid <= 1'b1;
        cmd <= c;
        column_x <= x;
        row_y <= y;
        column_bits <= bits;
        tall <= t;
        color <= col;
        page <= pg;
        read_addr <= addr;
        do
            @(posedge clk);
        while (!in_ready);
        r = blit_predict(c, x, y, bits, t, col, pg, addr);
        pending_replies.push_back(r);
        case (c)
            CMD_DRAW:
            begin
                draws_sent++;
                if (!r.applied)
                    draws_rejected++;
            end
            CMD_READ: reads_sent++;
            default: fills_sent++;
        endcase
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_replies.size() != 0);
    endtask

    task automatic send_random_word();
        int          pick;
        cmd_t        c;
        logic [6:0]  x;
        logic [5:0]  y;
        logic [23:0] bits;
        logic        t;
        logic        col;
        logic [1:0]  pg;
        logic [8:0]  addr;
        pick = $urandom_range(99);
        x = 7'($urandom);
        y = 6'($urandom);
        bits = 24'($urandom);
        t = 1'($urandom);
        col = 1'($urandom);
        pg = 2'($urandom);
        addr = 9'($urandom);
        if (pick < 55)
        begin
            c = CMD_DRAW;
            if ($urandom_range(1) == 0)
                x = 7'($urandom_range(0, 7));
            t = ($urandom_range(3) == 0);
            if ($urandom_range(19) != 0)
                y = t ? 6'($urandom_range(0, 8)) : 6'($urandom_range(0, ROWS - 1));
        end
        else if (pick < 93)
        begin
            c = CMD_READ;
            if ($urandom_range(1) == 0)
                addr = {2'($urandom_range(PAGES - 1)), 7'($urandom_range(0, 7))};
        end
        else if (pick < 98)
            c = CMD_FILL_PAGE;
        else
            c = CMD_FILL_ALL;
        send_word(c, x, y, bits, t, col, pg, addr);
    endtask

    task automatic test_directed_cases();
        send_word(CMD_READ, 0, 0, 0, 0, 0, 0, 9'd0);
        send_word(CMD_READ, 0, 0, 0, 0, 0, 0, 9'd511);
        send_word(CMD_DRAW, 7'd0, 6'd0, 24'h0000FF, 0, 1, 0, 0);
        send_word(CMD_READ, 0, 0, 0, 0, 0, 0, 9'd0);
        send_word(CMD_DRAW, 7'd127, 6'd7, 24'hFFFF55, 0, 1, 0, 0);
        send_word(CMD_READ, 0, 0, 0, 0, 0, 0, 9'd127);
        send_word(CMD_READ, 0, 0, 0, 0, 0, 0, 9'd255);
        send_word(CMD_DRAW, 7'd3, 6'd31, 24'h0000FF, 0, 1, 0, 0);
        send_word(CMD_DRAW, 7'd4, 6'd32, 24'hFFFFFF, 0, 1, 0, 0);
        send_word(CMD_DRAW, 7'd5, 6'd63, 24'hFFFFFF, 1, 1, 0, 0);
        send_word(CMD_DRAW, 7'd64, 6'd8, 24'hFFFFFF, 1, 1, 0, 0);
        send_word(CMD_DRAW, 7'd65, 6'd9, 24'hFFFFFF, 1, 1, 0, 0);
        send_word(CMD_DRAW, 7'd100, 6'd0, 24'hA5C3F0, 1, 1, 0, 0);
        send_word(CMD_DRAW, 7'd64, 6'd8, 24'h000000, 0, 1, 0, 0);
        send_word(CMD_DRAW, 7'd64, 6'd12, 24'h00000F, 0, 0, 0, 0);
        send_word(CMD_READ, 0, 0, 0, 0, 0, 0, 9'd192);
        send_word(CMD_FILL_PAGE, 0, 0, 0, 0, 1, 2'd0, 0);
        send_word(CMD_FILL_PAGE, 0, 0, 0, 0, 0, 2'd3, 0);
        send_word(CMD_READ, 0, 0, 0, 0, 0, 0, 9'd127);
        send_word(CMD_READ, 0, 0, 0, 0, 0, 0, 9'd448);
        send_word(CMD_FILL_ALL, 0, 0, 0, 0, 1, 0, 0);
        send_word(CMD_READ, 0, 0, 0, 0, 0, 0, 9'd511);
        send_word(CMD_FILL_PAGE, 0, 0, 0, 0, 0, 2'd2, 0);
        send_word(CMD_FILL_ALL, 0, 0, 0, 0, 0, 0, 0);
        send_word(CMD_READ, 0, 0, 0, 0, 0, 0, 9'd300);
    endtask

    task automatic test_random_pacing(int count, int sender_pct, int receiver_pct);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        repeat (count) send_random_word();
        hold_until_drained();
    endtask

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result word: read_data=%02h applied=%0b",
                             read_data, applied);
            end
            else
            begin
                want = pending_replies.pop_front();
                replies_checked++;
                if (read_data !== want.read_data || applied !== want.applied)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch on result %0d: expected %02h/%0b, got %02h/%0b",
                                 replies_checked, want.read_data, want.applied,
                                 read_data, applied);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        foreach (frame_shadow[i])
            frame_shadow[i] = FILL_ZEROS;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_cases();
        hold_until_drained();
        test_random_pacing(410, 23, 65);
        test_random_pacing(410, 65, 23);
        test_random_pacing(410, 0, 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d column draws (%0d rejected), %0d fills and %0d byte reads.",
                 draws_sent, draws_rejected, fills_sent, reads_sent);
        $display("Checked %0d result words under three pacing mixes; %0d mismatches, %0d missing.",
                 replies_checked, mismatches, pending_replies.size());
        if (mismatches == 0 && pending_replies.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
sv/fbcb_pkg.sv
sv/fbcb_ram.sv
sv/fbcb_seq.sv
sv/page_framebuffer_column_blit_unit.sv
tb/sv/page_framebuffer_column_blit_unit_tb.sv
